// ===== rtl/core/cpws_pkg.sv =====
package cpws_pkg;

    localparam int RING_SLOTS   = 13;
    localparam int CAPTURE_BITS = 24;

    localparam int IDX_W    = $clog2(RING_SLOTS);
    localparam int PERIOD_W = 25;
    localparam int DATA_W   = 32;
    localparam int DIV_CNT_W = $clog2(DATA_W);
    localparam int APB_ADDR_W = 3;
    localparam int WRAP_W   = 2;

    localparam logic [DATA_W-1:0] COUNT_CAP   = 32'h7EFF_FFFF;
    localparam logic [DATA_W-1:0] WRAP_STEP   = 32'd1 << CAPTURE_BITS;
    localparam logic [DATA_W-1:0] CAP_MASK    = WRAP_STEP - 32'd1;
    localparam logic [DATA_W-1:0] NUMER_RESET = 32'd3_000_000_000;

    localparam logic [WRAP_W-1:0] WRAP_LIMIT = 2'd2;

    localparam logic [APB_ADDR_W-3:0] REG_SPEED_NUMERATOR = '0;

    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [PERIOD_W-1:0] t_period;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } t_div_rsp;

    function automatic t_idx f_next_idx(input t_idx idx);
        if (idx >= t_idx'(RING_SLOTS - 1)) begin
            return '0;
        end
        return idx + t_idx'(1);
    endfunction

endpackage

// ===== rtl/core/cpws_ram.sv =====
module cpws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/cpws_div.sv =====
module cpws_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpws_pkg::t_div_req  i_req,
    output cpws_pkg::t_div_rsp  o_rsp
);
    import cpws_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt,  n_cnt;
    logic [DATA_W-1:0]    r_rem,  n_rem;
    logic [DATA_W-1:0]    r_quo,  n_quo;
    logic [DATA_W-1:0]    r_den,  n_den;

    logic [DATA_W:0] shifted;
    logic [DATA_W:0] trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        shifted = {r_rem, r_quo[DATA_W-1]};
        trial   = shifted - {1'b0, r_den};
        if (r_busy) begin
            // one quotient bit per cycle, restoring
            if (shifted >= {1'b0, r_den}) begin
                n_rem = trial[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(DATA_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_den  = i_req.divisor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== rtl/core/capture_period_window_speed_top.sv =====
// Each input beat walks S_IDLE, S_RING (only with a capture), S_DIVIDE, S_WAIT while the
// 32-step bit-serial divider runs, then S_FIN; S_WAIT is skipped when the window is not full
// or its sum is zero. o_stall holds new items off until the state is back in S_IDLE; a new
// item is taken while the previous result waits on the output.
// Synchronous active-low reset clears the window, counters, and the numerator to
// 3000000000; the ring reads as zero through per-slot valid bits, no clearing pass.
module capture_period_window_speed_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_overflow_event,
    input  logic                              i_capture_event,
    input  logic [23:0]                       i_capture_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [cpws_pkg::PERIOD_W-1:0]     o_latest_period,
    output logic [cpws_pkg::DATA_W-1:0]       o_period_sum,
    output logic                              o_window_full,
    output logic [cpws_pkg::DATA_W-1:0]       o_speed,
    output logic                              o_timed_out,
    output logic                              o_race_fixed,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cpws_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cpws_pkg::DATA_W-1:0]       pwdata,
    output logic [cpws_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import cpws_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RING   = 3'd1;
    localparam logic [2:0] S_DIVIDE = 3'd2;
    localparam logic [2:0] S_WAIT   = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0]              r_state, n_state;
    logic [DATA_W-1:0]       r_numer, n_numer;
    logic [WRAP_W-1:0]       r_wraps, n_wraps;
    logic                    r_race,  n_race;
    logic [CAPTURE_BITS-1:0] r_prev,  n_prev;
    t_idx                    r_idx,   n_idx;
    logic [DATA_W-1:0]       r_sum,   n_sum;
    logic                    r_full,  n_full;
    logic [RING_SLOTS-1:0]   r_vbits, n_vbits;
    t_period                 r_period, n_period;
    logic                    r_capt,  n_capt;
    logic                    r_timed, n_timed;
    logic                    r_fixed, n_fixed;
    logic [DATA_W-1:0]       r_speed, n_speed;

    logic                    r_out_valid, n_out_valid;
    t_period                 r_o_period,  n_o_period;
    logic [DATA_W-1:0]       r_o_sum,     n_o_sum;
    logic                    r_o_full,    n_o_full;
    logic [DATA_W-1:0]       r_o_speed,   n_o_speed;
    logic                    r_o_timed,   n_o_timed;
    logic                    r_o_fixed,   n_o_fixed;

    logic              accept;
    logic              cfg_wr;
    logic [DATA_W-1:0] count32;
    logic [WRAP_W-1:0] wraps_ov;
    logic              race_ov;
    logic              timeout;
    t_idx              base_idx;
    t_idx              ring_next;
    logic [DATA_W-1:0] cap32;
    logic              fix;
    logic [WRAP_W-1:0] wraps_cap;
    logic [DATA_W-1:0] raw;
    t_period           old_period;

    logic    ram_we;
    t_period ram_rdata;
    t_div_req div_req;
    t_div_rsp div_rsp;

    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr[APB_ADDR_W-1:2] == REG_SPEED_NUMERATOR) ? r_numer : '0;

    // overflow first: extend the count, or time out the window
    always_comb begin
        count32  = DATA_W'(r_wraps) << CAPTURE_BITS;
        wraps_ov = r_wraps;
        race_ov  = r_race;
        timeout  = 1'b0;
        if (i_overflow_event) begin
            if ((count32 < COUNT_CAP) && !r_race) begin
                wraps_ov = r_wraps + WRAP_W'(1);
            end
            race_ov = 1'b0;
            if (wraps_ov > WRAP_LIMIT) begin
                timeout  = 1'b1;
                wraps_ov = '0;
            end
        end
        base_idx = timeout ? t_idx'(0) : r_idx;
    end

    // capture: extend, correct a capture that beat the wrap, drop one wrap if long
    always_comb begin
        cap32     = DATA_W'(i_capture_value) & CAP_MASK;
        fix       = (DATA_W'(r_prev) > cap32) && (wraps_ov == '0);
        wraps_cap = fix ? WRAP_W'(1) : wraps_ov;
        raw       = (DATA_W'(wraps_cap) << CAPTURE_BITS) + cap32 - DATA_W'(r_prev);
        if (raw > WRAP_STEP) begin
            raw = raw - WRAP_STEP;
        end
    end

    assign ring_next  = f_next_idx((r_state == S_IDLE) ? base_idx : r_idx);
    assign old_period = r_vbits[ring_next] ? ram_rdata : '0;

    always_comb begin
        n_state  = r_state;
        n_numer  = cfg_wr && (paddr[APB_ADDR_W-1:2] == REG_SPEED_NUMERATOR) ? pwdata : r_numer;
        n_wraps  = r_wraps;
        n_race   = r_race;
        n_prev   = r_prev;
        n_idx    = r_idx;
        n_sum    = r_sum;
        n_full   = r_full;
        n_vbits  = r_vbits;
        n_period = r_period;
        n_capt   = r_capt;
        n_timed  = r_timed;
        n_fixed  = r_fixed;
        n_speed  = r_speed;
        ram_we   = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_numer;
        div_req.divisor  = r_sum;

        n_out_valid = r_out_valid && i_stall;
        n_o_period  = r_o_period;
        n_o_sum     = r_o_sum;
        n_o_full    = r_o_full;
        n_o_speed   = r_o_speed;
        n_o_timed   = r_o_timed;
        n_o_fixed   = r_o_fixed;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_wraps  = wraps_ov;
                    n_race   = race_ov;
                    n_idx    = base_idx;
                    n_timed  = timeout;
                    n_capt   = i_capture_event;
                    n_fixed  = 1'b0;
                    n_period = '0;
                    if (timeout) begin
                        n_vbits = '0;
                        n_sum   = '0;
                        n_full  = 1'b0;
                    end
                    if (i_capture_event) begin
                        n_wraps  = '0;
                        n_race   = fix ? 1'b1 : race_ov;
                        n_fixed  = fix;
                        n_prev   = cap32[CAPTURE_BITS-1:0];
                        n_period = raw[PERIOD_W-1:0];
                        n_state  = S_RING;
                    end else begin
                        n_state  = S_DIVIDE;
                    end
                end
            end
            S_RING: begin
                // write the new period, retire the slot that leaves the window
                ram_we = 1'b1;
                n_vbits[r_idx] = 1'b1;
                n_sum  = r_sum + DATA_W'(r_period) - DATA_W'(old_period);
                n_idx  = ring_next;
                if (ring_next == '0) begin
                    n_full = 1'b1;
                end
                n_state = S_DIVIDE;
            end
            S_DIVIDE: begin
                if (r_full && (r_sum != '0)) begin
                    div_req.start = 1'b1;
                    n_state = S_WAIT;
                end else begin
                    n_speed = '0;
                    n_state = S_FIN;
                end
            end
            S_WAIT: begin
                if (div_rsp.done) begin
                    n_speed = div_rsp.quotient;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_o_period  = r_period;
                    n_o_sum     = r_full ? r_sum : '0;
                    n_o_full    = r_full;
                    n_o_speed   = r_speed;
                    n_o_timed   = r_timed;
                    n_o_fixed   = r_fixed;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_numer     <= NUMER_RESET;
            r_wraps     <= '0;
            r_race      <= 1'b0;
            r_prev      <= '0;
            r_idx       <= '0;
            r_sum       <= '0;
            r_full      <= 1'b0;
            r_vbits     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_numer     <= n_numer;
            r_wraps     <= n_wraps;
            r_race      <= n_race;
            r_prev      <= n_prev;
            r_idx       <= n_idx;
            r_sum       <= n_sum;
            r_full      <= n_full;
            r_vbits     <= n_vbits;
            r_out_valid <= n_out_valid;
        end
        r_period   <= n_period;
        r_capt     <= n_capt;
        r_timed    <= n_timed;
        r_fixed    <= n_fixed;
        r_speed    <= n_speed;
        r_o_period <= n_o_period;
        r_o_sum    <= n_o_sum;
        r_o_full   <= n_o_full;
        r_o_speed  <= n_o_speed;
        r_o_timed  <= n_o_timed;
        r_o_fixed  <= n_o_fixed;
    end

    cpws_ram #(
        .WIDTH (PERIOD_W),
        .DEPTH (RING_SLOTS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_period),
        .i_raddr (ring_next),
        .o_rdata (ram_rdata)
    );

    cpws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_valid         = r_out_valid;
    assign o_latest_period = r_o_period;
    assign o_period_sum    = r_o_sum;
    assign o_window_full   = r_o_full;
    assign o_speed         = r_o_speed;
    assign o_timed_out     = r_o_timed;
    assign o_race_fixed    = r_o_fixed;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx < t_idx'(RING_SLOTS))
        else $error("ring pointer out of range");

    a_not_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_window_full) |-> (o_period_sum == '0) && (o_speed == '0))
        else $error("sum or speed reported before the window is full");

    a_timeout_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_timed_out) |-> !o_window_full)
        else $error("window full right after a timeout");

    a_fix_needs_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RING) |-> r_capt)
        else $error("ring update without a capture");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> (r_state == S_WAIT))
        else $error("divider launched outside the divide step");

endmodule

// ===== tb/sv/capture_period_window_speed_top_tb.sv =====
module capture_period_window_speed_top_tb;
    import cpws_pkg::*;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [DATA_W-1:0]   sum;
        logic                full;
        logic [DATA_W-1:0]   speed;
        logic                timed_out;
        logic                race_fixed;
    } t_speed_reading;

    logic                  i_clk;
    logic                  i_rst_n          = 1'b0;
    logic                  i_valid          = 1'b0;
    logic                  i_overflow_event = 1'b0;
    logic                  i_capture_event  = 1'b0;
    logic [23:0]           i_capture_value  = '0;
    logic                  i_stall          = 1'b0;
    logic                  psel             = 1'b0;
    logic                  penable          = 1'b0;
    logic                  pwrite           = 1'b0;
    logic [APB_ADDR_W-1:0] paddr            = '0;
    logic [DATA_W-1:0]     pwdata           = '0;

    logic                  o_stall;
    logic                  o_valid;
    logic [PERIOD_W-1:0]   o_latest_period;
    logic [DATA_W-1:0]     o_period_sum;
    logic                  o_window_full;
    logic [DATA_W-1:0]     o_speed;
    logic                  o_timed_out;
    logic                  o_race_fixed;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    // predictor state
    logic [DATA_W-1:0]     speed_numer = NUMER_RESET;
    logic [DATA_W-1:0]     wrap_ticks  = '0;
    logic [23:0]           last_capture = '0;
    logic                  race_hold   = 1'b0;
    logic [PERIOD_W-1:0]   period_ring [RING_SLOTS];
    int                    ring_slot;
    logic [DATA_W-1:0]     window_sum;
    logic                  window_full;

    t_speed_reading        pending_readings [$];
    int                    failures  = 0;
    int unsigned           items_sent = 0;
    int                    idle_pct  = 0;
    int                    stall_pct = 0;

    capture_period_window_speed_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_overflow_event (i_overflow_event),
        .i_capture_event  (i_capture_event),
        .i_capture_value  (i_capture_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_latest_period  (o_latest_period),
        .o_period_sum     (o_period_sum),
        .o_window_full    (o_window_full),
        .o_speed          (o_speed),
        .o_timed_out      (o_timed_out),
        .o_race_fixed     (o_race_fixed),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void clear_window();
        for (int k = 0; k < RING_SLOTS; k++) begin
            period_ring[k] = '0;
        end
        ring_slot   = 0;
        window_sum  = '0;
        window_full = 1'b0;
    endfunction

    function automatic t_speed_reading predict_speed_reading(input logic ov, input logic cev,
                                                             input logic [23:0] cap);
        t_speed_reading r;
        logic [DATA_W-1:0] span;
        r = '0;
        if (ov) begin
            if (wrap_ticks < COUNT_CAP && !race_hold) begin
                wrap_ticks = wrap_ticks + WRAP_STEP;
            end
            race_hold = 1'b0;
            if (wrap_ticks > (WRAP_STEP << 1)) begin
                clear_window();
                wrap_ticks  = '0;
                r.timed_out = 1'b1;
            end
        end
        if (cev) begin
            // capture beat the wrap: account for the wrap now, skip the late overflow
            if (last_capture > cap && wrap_ticks == '0) begin
                wrap_ticks   = wrap_ticks + WRAP_STEP;
                race_hold    = 1'b1;
                r.race_fixed = 1'b1;
            end
            span = wrap_ticks + {8'd0, cap} - {8'd0, last_capture};
            wrap_ticks   = '0;
            last_capture = cap;
            if (span > WRAP_STEP) begin
                span = span - WRAP_STEP;
            end
            r.period = span[PERIOD_W-1:0];
            window_sum = window_sum + DATA_W'(r.period);
            period_ring[ring_slot] = r.period;
            ring_slot = (ring_slot >= RING_SLOTS - 1) ? 0 : ring_slot + 1;
            window_sum = window_sum - DATA_W'(period_ring[ring_slot]);
            if (ring_slot == 0) begin
                window_full = 1'b1;
            end
        end
        r.full = window_full;
        if (window_full) begin
            r.sum = window_sum;
            if (window_sum != '0) begin
                r.speed = speed_numer / window_sum;
            end
        end
        return r;
    endfunction

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        t_speed_reading want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: result beat with no prediction waiting", $time);
                failures++;
            end else begin
                want = pending_readings.pop_front();
                check_field("latest_period", DATA_W'(want.period), DATA_W'(o_latest_period));
                check_field("period_sum", want.sum, o_period_sum);
                check_field("window_full", DATA_W'(want.full), DATA_W'(o_window_full));
                check_field("speed", want.speed, o_speed);
                check_field("timed_out", DATA_W'(want.timed_out), DATA_W'(o_timed_out));
                check_field("race_fixed", DATA_W'(want.race_fixed), DATA_W'(o_race_fixed));
            end
        end
    end

    task automatic send_item(input logic ov, input logic cev, input logic [23:0] cap);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_overflow_event <= ov;
        i_capture_event  <= cev;
        i_capture_value  <= cap;
        pending_readings.push_back(predict_speed_reading(ov, cev, cap));
        items_sent++;
        do begin
            @(posedge i_clk);
        end while (o_stall);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_readings.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_numerator(input logic [DATA_W-1:0] value);
        drain_results();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_SPEED_NUMERATOR, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        speed_numer = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_corner_cases();
        send_item(1'b0, 1'b0, 24'h000000);
        send_item(1'b0, 1'b1, 24'h000100);
        // capture below the previous one with no wrap seen: race correction
        send_item(1'b0, 1'b1, 24'h000050);
        send_item(1'b1, 1'b0, 24'h000000);
        send_item(1'b1, 1'b0, 24'h000000);
        // one wrap plus a full-scale capture: span above one timer span, one wrap dropped
        send_item(1'b0, 1'b1, 24'hFFFFFF);
        send_item(1'b1, 1'b1, 24'h000000);
        // third wrap without a capture times out
        send_item(1'b1, 1'b0, 24'hFFFFFF);
        send_item(1'b1, 1'b0, 24'h000000);
        send_item(1'b1, 1'b0, 24'h000000);
    endtask

    task automatic test_window_fill_and_timeout();
        // equal captures leave a full window whose sum is zero, then a real period
        for (int k = 0; k < 14; k++) begin
            send_item(1'b0, 1'b1, (k == 13) ? 24'h0F0000 : 24'h123456);
        end
        send_item(1'b1, 1'b0, 24'h000000);
        send_item(1'b1, 1'b0, 24'h000000);
        send_item(1'b1, 1'b0, 24'h000000);
    endtask

    task automatic test_rotation_stream(input int idle, input int stall,
                                        input logic [DATA_W-1:0] numer, input int beats);
        logic [DATA_W-1:0] span;
        logic [DATA_W-1:0] total;
        int unsigned       wraps;
        int unsigned       style;
        int unsigned       roll;
        int unsigned       stop_at;
        write_numerator(numer);
        idle_pct  = idle;
        stall_pct = stall;
        stop_at   = items_sent + beats;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 12) begin
                send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 24'($urandom()));
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 40) begin
                    span = $urandom_range(1, 1 << 18);
                end else if (roll < 75) begin
                    span = $urandom_range(1 << 18, 1 << 24);
                end else if (roll < 92) begin
                    span = $urandom_range(1 << 24, 3 << 23);
                end else begin
                    span = $urandom_range(3 << 23, 1 << 26);
                end
                total = {8'd0, last_capture} + span;
                wraps = 32'(total[31:24]);
                style = $urandom_range(0, 99);
                if (wraps == 1 && style < 20) begin
                    // edge lands just past the wrap, ahead of its overflow beat
                    send_item(1'b0, 1'b1, total[23:0]);
                    send_item(1'b1, 1'b0, 24'($urandom()));
                end else begin
                    for (int w = 0; w + 1 < wraps; w++) begin
                        send_item(1'b1, 1'b0, 24'($urandom()));
                    end
                    if (wraps != 0 && style < 50) begin
                        send_item(1'b1, 1'b1, total[23:0]);
                    end else begin
                        if (wraps != 0) begin
                            send_item(1'b1, 1'b0, 24'($urandom()));
                        end
                        send_item(1'b0, 1'b1, total[23:0]);
                    end
                end
            end
        end
    endtask

    initial begin
        clear_window();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_cases();
        test_window_fill_and_timeout();
        test_rotation_stream(0, 0, NUMER_RESET, 240);
        test_rotation_stream(48, 0, 32'hFFFF_FFFF, 240);
        test_rotation_stream(0, 48, 32'h0000_0000, 240);
        test_rotation_stream(7, 7, 32'h0000_0001, 240);
        test_rotation_stream(0, 0, 32'($urandom()), 240);
        test_rotation_stream(48, 0, NUMER_RESET, 240);
        test_rotation_stream(0, 48, 32'($urandom()), 240);
        test_rotation_stream(7, 7, 32'hFFFF_FFFF, 240);

        drain_results();
        repeat (40) @(posedge i_clk);
        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/cpws_pkg.sv
rtl/core/cpws_ram.sv
rtl/core/cpws_div.sv
rtl/core/capture_period_window_speed_top.sv
tb/sv/capture_period_window_speed_top_tb.sv
